// ----- rtl/core/arm_instruction_execute_step_unit_macros.svh -----
// ----------------------------------------------------------------------------
// ARM execute step unit assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARM_INSTRUCTION_EXECUTE_STEP_UNIT_MACROS_SVH
`define ARM_INSTRUCTION_EXECUTE_STEP_UNIT_MACROS_SVH

// Same-cycle implication
`define AIES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define AIES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/aies_pkg.sv -----
// ----------------------------------------------------------------------------
// ARM execute step package
// Types, codes, decode masks and constants shared by the execute step unit.
// ----------------------------------------------------------------------------
package aies_pkg;

    localparam int          NumRegsDefault = 16;
    localparam logic [31:0] StartAddrReset = 32'h0800_0000;
    localparam int          InTdataW       = 32;
    localparam int          OutTdataW      = 80;

    // Decode masks and match values, tested in priority order
    localparam logic [31:0] MaskOp    = 32'h0F00_0000;
    localparam logic [31:0] MatchSwi  = 32'h0F00_0000;
    localparam logic [31:0] MatchBl   = 32'h0B00_0000;
    localparam logic [31:0] MatchB    = 32'h0A00_0000;
    localparam logic [31:0] MaskLdm   = 32'h0E10_0000;
    localparam logic [31:0] MatchLdm  = 32'h0810_0000;
    localparam logic [31:0] MaskLdst  = 32'h0C10_0000;
    localparam logic [31:0] MatchLdr  = 32'h0410_0000;
    localparam logic [31:0] MatchStr  = 32'h0400_0000;
    localparam logic [31:0] MaskBx    = 32'h0FFF_FFF0;
    localparam logic [31:0] MatchBx   = 32'h012F_FF10;
    localparam logic [31:0] MaskSwp   = 32'h0FB0_0FF0;
    localparam logic [31:0] MatchSwp  = 32'h0100_0090;
    localparam logic [31:0] MaskMul   = 32'h0FE0_00F0;
    localparam logic [31:0] MatchMla  = 32'h0020_0090;
    localparam logic [31:0] MatchMul  = 32'h0000_0090;
    localparam logic [31:0] MaskMrs   = 32'h0FBF_0FFF;
    localparam logic [31:0] MatchMrs  = 32'h010F_0000;
    localparam logic [31:0] MaskMsrR  = 32'h0FBF_FFF0;
    localparam logic [31:0] MatchMsrR = 32'h0129_F000;
    localparam logic [31:0] MaskMsrF  = 32'h0DBF_F000;
    localparam logic [31:0] MatchMsrF = 32'h0128_F000;
    localparam logic [31:0] MaskDp    = 32'h0C00_0000;
    localparam logic [31:0] MatchDp   = 32'h0000_0000;

    typedef enum logic [3:0] {
        CLS_SWI = 4'd0,  CLS_BL  = 4'd1,  CLS_B   = 4'd2,  CLS_LDM = 4'd3,
        CLS_LDR = 4'd4,  CLS_STR = 4'd5,  CLS_BX  = 4'd6,  CLS_SWP = 4'd7,
        CLS_MLA = 4'd8,  CLS_MUL = 4'd9,  CLS_DP  = 4'd10, CLS_MRS = 4'd11,
        CLS_MSR = 4'd12, CLS_UND = 4'd13
    } aies_class_t;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
        COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
        COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
        COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
    } aies_cond_t;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
        OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
        OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
        OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
    } aies_opcode_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
    } aies_shift_t;

    // Execute result, one per instruction
    typedef struct packed {
        logic [3:0]  instr_class;
        logic        cond_passed;
        logic [31:0] alu_result;
        logic        dest_written;
        logic [3:0]  dest_index;
        logic [3:0]  flags_nzcv;
        logic [31:0] next_pc;
        logic        thumb_mode;
        logic        reg_we;
    } aies_result_t;

    // Register file write port
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } aies_wr_t;

endpackage

// ----- rtl/core/arm_instruction_execute_step_unit.sv -----
// Each input transaction passes the instruction register, then the result register.
// Throughput: one instruction per cycle while the master side accepts; the
//   execute stage between the instruction and result registers handles one per clock.
// Reset (rst_n, async low): PC = 0x0800_0000, R0..R14 read as zero,
//   flags NZCV = 0, ARM state, both pipeline registers empty.
// ----------------------------------------------------------------------------
// ARM execute step unit
// Single-pass ARM-state execute stage: data processing, B, BL and BX with
// a 15-entry register file, PC, flags and Thumb bit held here.
// ----------------------------------------------------------------------------
module arm_instruction_execute_step_unit
    import aies_pkg::*;
#(
    parameter int NUM_REGS = NumRegsDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // start address write: reloads the PC
    input  logic                 cfg_wen,
    input  logic [31:0]          cfg_wdata,
    // instruction_word[31:0]
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [InTdataW-1:0]  s_axis_tdata,
    // instr_class[3:0], cond_passed[4], alu_result[36:5], dest_written[37],
    // dest_index[41:38], flags_nzcv[45:42], next_pc[77:46], thumb_mode[78],
    // zero pad [79]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OutTdataW-1:0] m_axis_tdata
);

    logic         in_valid_reg;
    logic [31:0]  instr_reg;
    logic         out_valid_reg;
    aies_result_t out_reg;
    logic [31:0]  pc_reg;
    logic [3:0]   flags_reg;
    logic         thumb_reg;
    logic         in_fire, exec_fire;
    logic [31:0]  rn_data, rm_data, rs_data;
    aies_result_t res;
    aies_wr_t     wr;

    // Handshake: execute when result register is free or draining
    assign exec_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || exec_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Instruction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            instr_reg <= s_axis_tdata;
    end

    // Register file write from the executing instruction
    assign wr.en   = exec_fire && res.reg_we;
    assign wr.addr = res.dest_index;
    assign wr.data = res.alu_result;

    aies_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (in_fire),
        .rn_addr (s_axis_tdata[19:16]),
        .rm_addr (s_axis_tdata[3:0]),
        .rs_addr (s_axis_tdata[11:8]),
        .rn_data (rn_data),
        .rm_data (rm_data),
        .rs_data (rs_data)
    );

    aies_execute #(
        .NUM_REGS (NUM_REGS)
    ) u_execute (
        .instr   (instr_reg),
        .rn_data (rn_data),
        .rm_data (rm_data),
        .rs_data (rs_data),
        .pc      (pc_reg),
        .flags   (flags_reg),
        .thumb   (thumb_reg),
        .res     (res)
    );

    // Architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= StartAddrReset;
            flags_reg <= '0;
            thumb_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            pc_reg <= cfg_wdata;
        end
        else if (exec_fire)
        begin
            pc_reg    <= res.next_pc;
            flags_reg <= res.flags_nzcv;
            thumb_reg <= res.thumb_mode;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec_fire)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
            out_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.thumb_mode, out_reg.next_pc,
                            out_reg.flags_nzcv, out_reg.dest_index,
                            out_reg.dest_written, out_reg.alu_result,
                            out_reg.cond_passed, out_reg.instr_class};

endmodule

// ----- rtl/core/aies_regfile.sv -----
// ----------------------------------------------------------------------------
// ARM execute step register file
// R0..R14 in two write-mirrored banks, three registered read ports with
// write bypass; per-entry valid bits give the all-zero reset value.
// ----------------------------------------------------------------------------
module aies_regfile
    import aies_pkg::*;
#(
    parameter int NUM_REGS = NumRegsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  aies_wr_t    wr,
    input  logic        rd_en,
    input  logic [3:0]  rn_addr,
    input  logic [3:0]  rm_addr,
    input  logic [3:0]  rs_addr,
    output logic [31:0] rn_data,
    output logic [31:0] rm_data,
    output logic [31:0] rs_data
);

    localparam int          Depth = NUM_REGS - 1;
    localparam logic [3:0]  PcIdx = 4'(NUM_REGS - 1);

    logic [31:0]      bank_a [Depth];
    logic [31:0]      bank_b [Depth];
    logic [Depth-1:0] valid_reg;
    logic [31:0]      rn_data_reg;
    logic [31:0]      rm_data_reg;
    logic [31:0]      rs_data_reg;

    // Valid bits: cleared at reset, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // Bank writes, both banks mirror each other
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            bank_a[wr.addr] <= wr.data;
            bank_b[wr.addr] <= wr.data;
        end
    end

    // Registered reads; a write at the same edge is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && wr.addr == rn_addr)
                rn_data_reg <= wr.data;
            else if (rn_addr != PcIdx && valid_reg[rn_addr])
                rn_data_reg <= bank_a[rn_addr];
            else
                rn_data_reg <= '0;

            if (wr.en && wr.addr == rm_addr)
                rm_data_reg <= wr.data;
            else if (rm_addr != PcIdx && valid_reg[rm_addr])
                rm_data_reg <= bank_a[rm_addr];
            else
                rm_data_reg <= '0;

            if (wr.en && wr.addr == rs_addr)
                rs_data_reg <= wr.data;
            else if (rs_addr != PcIdx && valid_reg[rs_addr])
                rs_data_reg <= bank_b[rs_addr];
            else
                rs_data_reg <= '0;
        end
    end

    assign rn_data = rn_data_reg;
    assign rm_data = rm_data_reg;
    assign rs_data = rs_data_reg;

endmodule

// ----- rtl/core/aies_execute.sv -----
// ----------------------------------------------------------------------------
// ARM execute step datapath
// Decode, condition test, barrel shifter and ALU for one instruction.
// Purely combinational; operands arrive from registered file reads.
// ----------------------------------------------------------------------------
module aies_execute
    import aies_pkg::*;
#(
    parameter int NUM_REGS = NumRegsDefault
)
(
    input  logic [31:0]  instr,
    input  logic [31:0]  rn_data,
    input  logic [31:0]  rm_data,
    input  logic [31:0]  rs_data,
    input  logic [31:0]  pc,
    input  logic [3:0]   flags,
    input  logic         thumb,
    output aies_result_t res
);

    localparam logic [3:0] PcIdx = 4'(NUM_REGS - 1);
    localparam logic [3:0] LrIdx = 4'd14;

    aies_class_t  cls;
    logic         passed;
    logic         flag_n, flag_z, flag_c, flag_v;
    logic         imm, by_reg;
    logic [31:0]  pcv, op1, rm_v, rs_v, bx_target, op2;
    logic [7:0]   amt;
    logic [4:0]   amt5;
    logic         sc;
    logic [32:0]  lsl_w, lsr_w, asr_w;
    logic [31:0]  ror_w, imm_rot;
    logic [63:0]  ror_dbl, imm_dbl;
    logic [31:0]  add_x, add_y;
    logic         add_cin;
    logic [32:0]  sum;
    logic         add_v;
    logic [31:0]  logic_r, dp_r;
    logic         dp_c, dp_v, is_arith;
    logic [31:0]  br_off;
    aies_opcode_t opc;
    logic [3:0]   rd;

    assign {flag_n, flag_z, flag_c, flag_v} = flags;
    assign opc = aies_opcode_t'(instr[24:21]);
    assign rd  = instr[15:12];

    // Classification in priority order
    always_comb
    begin
        if      ((instr & MaskOp)   == MatchSwi)  cls = CLS_SWI;
        else if ((instr & MaskOp)   == MatchBl)   cls = CLS_BL;
        else if ((instr & MaskOp)   == MatchB)    cls = CLS_B;
        else if ((instr & MaskLdm)  == MatchLdm)  cls = CLS_LDM;
        else if ((instr & MaskLdst) == MatchLdr)  cls = CLS_LDR;
        else if ((instr & MaskLdst) == MatchStr)  cls = CLS_STR;
        else if ((instr & MaskBx)   == MatchBx)   cls = CLS_BX;
        else if ((instr & MaskSwp)  == MatchSwp)  cls = CLS_SWP;
        else if ((instr & MaskMul)  == MatchMla)  cls = CLS_MLA;
        else if ((instr & MaskMul)  == MatchMul)  cls = CLS_MUL;
        else if ((instr & MaskMrs)  == MatchMrs)  cls = CLS_MRS;
        else if ((instr & MaskMsrR) == MatchMsrR) cls = CLS_MSR;
        else if ((instr & MaskMsrF) == MatchMsrF) cls = CLS_MSR;
        else if ((instr & MaskDp)   == MatchDp)   cls = CLS_DP;
        else                                       cls = CLS_UND;
    end

    // Condition test against current NZCV
    always_comb
    begin
        case (aies_cond_t'(instr[31:28]))
            COND_EQ: passed = flag_z;
            COND_NE: passed = !flag_z;
            COND_CS: passed = flag_c;
            COND_CC: passed = !flag_c;
            COND_MI: passed = flag_n;
            COND_PL: passed = !flag_n;
            COND_VS: passed = flag_v;
            COND_VC: passed = !flag_v;
            COND_HI: passed = flag_c && !flag_z;
            COND_LS: passed = !flag_c || flag_z;
            COND_GE: passed = (flag_n == flag_v);
            COND_LT: passed = (flag_n != flag_v);
            COND_GT: passed = !flag_z && (flag_n == flag_v);
            COND_LE: passed = flag_z || (flag_n != flag_v);
            COND_AL: passed = 1'b1;
            default: passed = 1'b0;
        endcase
    end

    // Operand fetch; R15 reads as PC+8, or PC+12 with a register shift
    assign imm       = instr[25];
    assign by_reg    = !imm && instr[4];
    assign pcv       = pc + (by_reg ? 32'd12 : 32'd8);
    assign op1       = (instr[19:16] == PcIdx) ? pcv : rn_data;
    assign rm_v      = (instr[3:0]   == PcIdx) ? pcv : rm_data;
    assign rs_v      = (instr[11:8]  == PcIdx) ? pcv : rs_data;
    assign bx_target = (instr[3:0]   == PcIdx) ? (pc + 32'd8) : rm_data;

    // Barrel shifter building blocks
    assign amt     = by_reg ? rs_v[7:0] : {3'b000, instr[11:7]};
    assign amt5    = amt[4:0];
    assign lsl_w   = {1'b0, rm_v} << amt5;
    assign lsr_w   = {rm_v, 1'b0} >> amt5;
    assign asr_w   = 33'($signed({rm_v, 1'b0}) >>> amt5);
    assign ror_dbl = {rm_v, rm_v} >> amt5;
    assign ror_w   = ror_dbl[31:0];
    assign imm_dbl = {24'd0, instr[7:0], 24'd0, instr[7:0]} >> {instr[11:8], 1'b0};
    assign imm_rot = imm_dbl[31:0];

    // Second operand and shifter carry
    always_comb
    begin
        op2 = rm_v;
        sc  = flag_c;
        if (imm)
        begin
            op2 = imm_rot;
            sc  = (instr[11:8] != 4'd0) ? imm_rot[31] : flag_c;
        end
        else if (!by_reg && amt == 8'd0)
        begin
            case (aies_shift_t'(instr[6:5]))
                SH_LSL:
                begin
                    op2 = rm_v;
                    sc  = flag_c;
                end
                SH_LSR:
                begin
                    op2 = '0;
                    sc  = rm_v[31];
                end
                SH_ASR:
                begin
                    op2 = {32{rm_v[31]}};
                    sc  = rm_v[31];
                end
                default:
                begin
                    op2 = {flag_c, rm_v[31:1]};
                    sc  = rm_v[0];
                end
            endcase
        end
        else if (amt == 8'd0)
        begin
            op2 = rm_v;
            sc  = flag_c;
        end
        else
        begin
            case (aies_shift_t'(instr[6:5]))
                SH_LSL:
                begin
                    if (amt < 8'd32)
                    begin
                        op2 = lsl_w[31:0];
                        sc  = lsl_w[32];
                    end
                    else
                    begin
                        op2 = '0;
                        sc  = (amt == 8'd32) ? rm_v[0] : 1'b0;
                    end
                end
                SH_LSR:
                begin
                    if (amt < 8'd32)
                    begin
                        op2 = lsr_w[32:1];
                        sc  = lsr_w[0];
                    end
                    else
                    begin
                        op2 = '0;
                        sc  = (amt == 8'd32) ? rm_v[31] : 1'b0;
                    end
                end
                SH_ASR:
                begin
                    if (amt < 8'd32)
                    begin
                        op2 = asr_w[32:1];
                        sc  = asr_w[0];
                    end
                    else
                    begin
                        op2 = {32{rm_v[31]}};
                        sc  = rm_v[31];
                    end
                end
                default:
                begin
                    op2 = ror_w;
                    sc  = ror_w[31];
                end
            endcase
        end
    end

    // Adder operand selection, one shared adder
    always_comb
    begin
        add_x    = op1;
        add_y    = op2;
        add_cin  = 1'b0;
        is_arith = 1'b1;
        case (opc)
            OP_SUB, OP_CMP:
            begin
                add_y   = ~op2;
                add_cin = 1'b1;
            end
            OP_RSB:
            begin
                add_x   = op2;
                add_y   = ~op1;
                add_cin = 1'b1;
            end
            OP_ADD, OP_CMN: add_cin = 1'b0;
            OP_ADC:         add_cin = flag_c;
            OP_SBC:
            begin
                add_y   = ~op2;
                add_cin = flag_c;
            end
            OP_RSC:
            begin
                add_x   = op2;
                add_y   = ~op1;
                add_cin = flag_c;
            end
            default: is_arith = 1'b0;
        endcase
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
    assign add_v = (~(add_x[31] ^ add_y[31])) & (add_x[31] ^ sum[31]);

    // Logical ops
    always_comb
    begin
        case (opc)
            OP_AND, OP_TST: logic_r = op1 & op2;
            OP_EOR, OP_TEQ: logic_r = op1 ^ op2;
            OP_ORR:         logic_r = op1 | op2;
            OP_MOV:         logic_r = op2;
            OP_BIC:         logic_r = op1 & ~op2;
            default:        logic_r = ~op2;
        endcase
    end

    assign dp_r = is_arith ? sum[31:0] : logic_r;
    assign dp_c = is_arith ? sum[32]   : sc;
    assign dp_v = is_arith ? add_v     : flag_v;

    assign br_off = {{6{instr[23]}}, instr[23:0], 2'b00};

    // Result assembly
    always_comb
    begin
        res              = '0;
        res.instr_class  = cls;
        res.cond_passed  = passed;
        res.flags_nzcv   = flags;
        res.next_pc      = pc + 32'd4;
        res.thumb_mode   = thumb;
        if (passed)
        begin
            case (cls)
                CLS_B:
                begin
                    res.next_pc = pc + 32'd8 + br_off;
                end
                CLS_BL:
                begin
                    res.next_pc      = pc + 32'd8 + br_off;
                    res.alu_result   = pc + 32'd4;
                    res.dest_written = 1'b1;
                    res.dest_index   = LrIdx;
                    res.reg_we       = 1'b1;
                end
                CLS_BX:
                begin
                    res.thumb_mode = bx_target[0];
                    res.next_pc    = bx_target[0] ? {bx_target[31:1], 1'b0}
                                                  : {bx_target[31:2], 2'b00};
                end
                CLS_DP:
                begin
                    res.alu_result = dp_r;
                    if (instr[20] && rd != PcIdx)
                        res.flags_nzcv = {dp_r[31], (dp_r == 32'd0), dp_c, dp_v};
                    // compares never write a register
                    if (!(opc == OP_TST || opc == OP_TEQ || opc == OP_CMP
                          || opc == OP_CMN))
                    begin
                        res.dest_written = 1'b1;
                        res.dest_index   = rd;
                        if (rd == PcIdx)
                            res.next_pc = {dp_r[31:2], 2'b00};
                        else
                            res.reg_we = 1'b1;
                    end
                end
                default:
                begin
                    res.next_pc = pc + 32'd4;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/aies_checker.sv -----
// ----------------------------------------------------------------------------
// ARM execute step port checker
// Watches the top-level ports for result consistency and output stability.
// ----------------------------------------------------------------------------
`include "arm_instruction_execute_step_unit_macros.svh"

module aies_checker
    import aies_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OutTdataW-1:0] m_axis_tdata
);

    // Stalled result transaction holds
    `AIES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Failed condition leaves no result and no write
    `AIES_ASSERT_NOW(a_fail_quiet, m_axis_tvalid && !m_axis_tdata[4], m_axis_tdata[36:5] == 32'd0 && !m_axis_tdata[37], "failed condition produced a result")

    // No write reports index zero
    `AIES_ASSERT_NOW(a_dest_zero, m_axis_tvalid && !m_axis_tdata[37], m_axis_tdata[41:38] == 4'd0, "dest index set without a write")

    // Class code in range
    `AIES_ASSERT_NOW(a_class_range, m_axis_tvalid, m_axis_tdata[3:0] != 4'd14 && m_axis_tdata[3:0] != 4'd15, "class code out of range")

endmodule

bind arm_instruction_execute_step_unit aies_checker u_aies_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
